// File: hw/rtl/gaussian_integer_alu_core_defines.svh
// Assertion macros shared by the checker.
`ifndef GAUSSIAN_INTEGER_ALU_CORE_DEFINES_SVH
`define GAUSSIAN_INTEGER_ALU_CORE_DEFINES_SVH

// Implication checked on every edge outside reset.
`define GIA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gia: implication check failed");

// Next-cycle implication checked on every edge outside reset.
`define GIA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gia: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define GIA_ASSERT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gia: reset check failed");

`endif

// File: hw/rtl/gia_pkg.sv
`timescale 1ns / 1ps
package gia_pkg;

  localparam int OPW    = 16;
  localparam int RES_W  = 33;
  localparam int PW     = 2 * OPW;
  localparam int DW     = 2 * OPW;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  typedef enum logic [5:0] {
    OP_ADD = 6'b000001,
    OP_SUB = 6'b000010,
    OP_MUL = 6'b000100,
    OP_DIV = 6'b001000,
    OP_CMP = 6'b010000,
    OP_NOP = 6'b100000
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic signed [OPW-1:0] ar;
    logic signed [OPW-1:0] ai;
    logic signed [OPW-1:0] br;
    logic signed [OPW-1:0] bi;
  } item_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] num;
  } divw_t;

  // One restoring-division bit: shift numerator MSB into remainder, subtract if it fits.
  function automatic divw_t div_step(logic [DW-1:0] rem, logic [DW-1:0] num,
                                     logic [DW-1:0] den);
    divw_t    r;
    logic [DW:0] t;
    t     = {rem, num[DW-1]};
    r.num = {num[DW-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      t        = t - {1'b0, den};
      r.num[0] = 1'b1;
    end
    r.rem = t[DW-1:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/gaussian_integer_alu_core.sv
`timescale 1ns / 1ps
// Complex-integer ALU: add, subtract, multiply, divide (truncating toward zero)
// and compare on two 16-bit complex operands, one request per cycle while the output is not stalled.
// Every request takes the same path, so results leave in request order.
// From acceptance to result valid, the request is written into the input
// queue at the accepting edge, then passes the operand register, product
// register, numerator/denominator register, 32 restoring-divider stages (one
// quotient bit each) and the output register. The divider pipeline makes up
// most of the pipeline depth.
// A four-entry queue parts the input side from the arithmetic pipeline; when
// a valid output is stalled the whole pipeline holds and the queue absorbs
// new requests until full, then in_stall rises.
module gaussian_integer_alu_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       kind,
  input  logic signed [gia_pkg::OPW-1:0]   a_real,
  input  logic signed [gia_pkg::OPW-1:0]   a_imag,
  input  logic signed [gia_pkg::OPW-1:0]   b_real,
  input  logic signed [gia_pkg::OPW-1:0]   b_imag,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [gia_pkg::RES_W-1:0] res_real,
  output logic signed [gia_pkg::RES_W-1:0] res_imag,
  output logic                             equal,
  output logic                             div_zero
);
  import gia_pkg::*;

  // Queue head toward the arithmetic pipeline.
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // Accept, decode the operation and buffer the request.
  gia_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .a_real   (a_real),
    .a_imag   (a_imag),
    .b_real   (b_real),
    .b_imag   (b_imag),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Multiply, combine and divide; advance only when the output can move.
  gia_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_real  (res_real),
    .res_imag  (res_imag),
    .equal     (equal),
    .div_zero  (div_zero)
  );

endmodule

// File: hw/rtl/gia_front.sv
`timescale 1ns / 1ps
module gia_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    kind,
  input  logic signed [gia_pkg::OPW-1:0] a_real,
  input  logic signed [gia_pkg::OPW-1:0] a_imag,
  input  logic signed [gia_pkg::OPW-1:0] b_real,
  input  logic signed [gia_pkg::OPW-1:0] b_imag,
  output logic                          q_valid,
  output gia_pkg::item_t                q_item,
  input  logic                          q_pop
);
  import gia_pkg::*;

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;
  logic           push;
  item_t          dec;

  always_comb begin
    dec.ar = a_real;
    dec.ai = a_imag;
    dec.br = b_real;
    dec.bi = b_imag;
    case (kind)
      KIND_ADD: dec.op = OP_ADD;
      KIND_SUB: dec.op = OP_SUB;
      KIND_MUL: dec.op = OP_MUL;
      KIND_DIV: dec.op = OP_DIV;
      KIND_CMP: dec.op = OP_CMP;
      default:  dec.op = OP_NOP;
    endcase
  end

  assign in_stall = (cnt == (QAW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != '0);
  assign q_item   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (q_pop) rp <= rp + 1'b1;
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end
  end

endmodule

// File: hw/rtl/gia_back.sv
`timescale 1ns / 1ps
module gia_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  gia_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [gia_pkg::RES_W-1:0] res_real,
  output logic signed [gia_pkg::RES_W-1:0] res_imag,
  output logic                             equal,
  output logic                             div_zero
);
  import gia_pkg::*;

  typedef struct packed {
    op_t                     op;
    logic signed [PW-1:0]    p_rr;
    logic signed [PW-1:0]    p_ii;
    logic signed [PW-1:0]    p_ri;
    logic signed [PW-1:0]    p_ir;
    logic signed [PW-1:0]    p_bb;
    logic signed [PW-1:0]    p_cc;
    logic signed [RES_W-1:0] sum_r;
    logic signed [RES_W-1:0] sum_i;
    logic                    eq;
  } prod_t;

  typedef struct packed {
    logic                    is_div;
    logic                    dz;
    logic                    eq;
    logic signed [RES_W-1:0] res_r;
    logic signed [RES_W-1:0] res_i;
    logic                    neg_r;
    logic                    neg_i;
    logic [DW-1:0]           den;
    logic [DW-1:0]           rem_r;
    logic [DW-1:0]           num_r;
    logic [DW-1:0]           rem_i;
    logic [DW-1:0]           num_i;
  } dstage_t;

  logic    adv;
  logic    v0;
  item_t   it0;
  logic    v1;
  prod_t   s1;
  logic    dv [DW+1];
  dstage_t ds [DW+1];
  dstage_t dn [DW];
  dstage_t d0_next;
  logic signed [RES_W-1:0] nr;
  logic signed [RES_W-1:0] ni;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (adv) begin
      it0 <= q_item;
      s1.op    <= it0.op;
      s1.p_rr  <= it0.ar * it0.br;
      s1.p_ii  <= it0.ai * it0.bi;
      s1.p_ri  <= it0.ar * it0.bi;
      s1.p_ir  <= it0.ai * it0.br;
      s1.p_bb  <= it0.br * it0.br;
      s1.p_cc  <= it0.bi * it0.bi;
      s1.sum_r <= (it0.op == OP_SUB) ? RES_W'(it0.ar) - RES_W'(it0.br)
                                     : RES_W'(it0.ar) + RES_W'(it0.br);
      s1.sum_i <= (it0.op == OP_SUB) ? RES_W'(it0.ai) - RES_W'(it0.bi)
                                     : RES_W'(it0.ai) + RES_W'(it0.bi);
      s1.eq    <= (it0.ar == it0.br) && (it0.ai == it0.bi);
    end
  end

  // Numerators and denominator for divide; final results for the other ops.
  always_comb begin
    nr = RES_W'(s1.p_rr) + RES_W'(s1.p_ii);
    ni = RES_W'(s1.p_ir) - RES_W'(s1.p_ri);
    d0_next.is_div = (s1.op == OP_DIV);
    d0_next.den    = DW'($unsigned(s1.p_bb)) + DW'($unsigned(s1.p_cc));
    d0_next.dz     = (s1.op == OP_DIV) && (d0_next.den == '0);
    d0_next.eq     = (s1.op == OP_CMP) && s1.eq;
    d0_next.neg_r  = nr[RES_W-1];
    d0_next.neg_i  = ni[RES_W-1];
    d0_next.num_r  = nr[RES_W-1] ? DW'(-nr) : DW'(nr);
    d0_next.num_i  = ni[RES_W-1] ? DW'(-ni) : DW'(ni);
    d0_next.rem_r  = '0;
    d0_next.rem_i  = '0;
    case (s1.op)
      OP_ADD, OP_SUB: begin
        d0_next.res_r = s1.sum_r;
        d0_next.res_i = s1.sum_i;
      end
      OP_MUL: begin
        d0_next.res_r = RES_W'(s1.p_rr) - RES_W'(s1.p_ii);
        d0_next.res_i = RES_W'(s1.p_ri) + RES_W'(s1.p_ir);
      end
      default: begin
        d0_next.res_r = '0;
        d0_next.res_i = '0;
      end
    endcase
  end

  // One quotient bit per stage for both parts.
  always_comb begin
    divw_t wr;
    divw_t wi;
    for (int k = 0; k < DW; k++) begin
      wr          = div_step(ds[k].rem_r, ds[k].num_r, ds[k].den);
      wi          = div_step(ds[k].rem_i, ds[k].num_i, ds[k].den);
      dn[k]       = ds[k];
      dn[k].rem_r = wr.rem;
      dn[k].num_r = wr.num;
      dn[k].rem_i = wi.rem;
      dn[k].num_i = wi.num;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0] <= d0_next;
      for (int k = 0; k < DW; k++) begin
        ds[k+1] <= dn[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      equal    <= ds[DW].eq;
      div_zero <= ds[DW].dz;
      if (ds[DW].is_div) begin
        if (ds[DW].dz) begin
          res_real <= '0;
          res_imag <= '0;
        end else begin
          res_real <= ds[DW].neg_r ? -{1'b0, ds[DW].num_r} : {1'b0, ds[DW].num_r};
          res_imag <= ds[DW].neg_i ? -{1'b0, ds[DW].num_i} : {1'b0, ds[DW].num_i};
        end
      end else begin
        res_real <= ds[DW].res_r;
        res_imag <= ds[DW].res_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      for (int k = 0; k <= DW; k++) begin
        dv[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      v0        <= q_valid;
      v1        <= v0;
      dv[0]     <= v1;
      for (int k = 0; k < DW; k++) begin
        dv[k+1] <= dv[k];
      end
      out_valid <= dv[DW];
    end
  end

endmodule

// File: hw/rtl/gia_checker.sv
`timescale 1ns / 1ps
`include "gaussian_integer_alu_core_defines.svh"
module gia_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [gia_pkg::RES_W-1:0] res_real,
  input logic signed [gia_pkg::RES_W-1:0] res_imag,
  input logic                             equal,
  input logic                             div_zero
);

  // A stalled result stays offered.
  `GIA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  // Divide by zero yields zero parts and no equal flag.
  `GIA_ASSERT_IMP(a_dz_zero, out_valid && div_zero, res_real == '0 && res_imag == '0 && !equal)
  // A compare match yields zero parts and no divide flag.
  `GIA_ASSERT_IMP(a_eq_zero, out_valid && equal, res_real == '0 && res_imag == '0 && !div_zero)
  // Reset empties the output.
  `GIA_ASSERT_ALL(a_rst_empty, rst, !out_valid)

endmodule

bind gaussian_integer_alu_core gia_checker u_gia_checker (.*);

// File: tb/gia_checker.sv
`timescale 1ns / 1ps
module gia_scoreboard (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [2:0]                       kind,
  input  logic signed [gia_pkg::OPW-1:0]   a_real,
  input  logic signed [gia_pkg::OPW-1:0]   a_imag,
  input  logic signed [gia_pkg::OPW-1:0]   b_real,
  input  logic signed [gia_pkg::OPW-1:0]   b_imag,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [gia_pkg::RES_W-1:0] res_real,
  input  logic signed [gia_pkg::RES_W-1:0] res_imag,
  input  logic                             equal,
  input  logic                             div_zero,
  output int                               fail_count,
  output int                               pending
);
  import gia_pkg::*;

  typedef struct packed {
    logic signed [RES_W-1:0] re;
    logic signed [RES_W-1:0] im;
    logic                    eq;
    logic                    dz;
  } alu_result_t;

  alu_result_t result_fifo[$];

  // Exact arithmetic in 128 bits, then wrap to the result width.
  function automatic alu_result_t compute_result(logic [2:0] k,
      logic signed [OPW-1:0] ar, logic signed [OPW-1:0] ai,
      logic signed [OPW-1:0] br, logic signed [OPW-1:0] bi);
    alu_result_t r;
    logic signed [127:0] xr, xi, yr, yi, den, nr, ni;
    r = '0;
    xr = ar; xi = ai; yr = br; yi = bi;
    case (k)
      KIND_ADD: begin
        r.re = RES_W'(xr + yr);
        r.im = RES_W'(xi + yi);
      end
      KIND_SUB: begin
        r.re = RES_W'(xr - yr);
        r.im = RES_W'(xi - yi);
      end
      KIND_MUL: begin
        r.re = RES_W'(xr * yr - xi * yi);
        r.im = RES_W'(xr * yi + xi * yr);
      end
      KIND_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          nr = xr * yr + xi * yi;
          ni = xi * yr - xr * yi;
          // signed division truncates toward zero
          r.re = RES_W'(nr / den);
          r.im = RES_W'(ni / den);
        end
      end
      KIND_CMP: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    alu_result_t e;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      result_fifo.delete();
    end else begin
      if (in_valid && !in_stall)
        result_fifo.push_back(compute_result(kind, a_real, a_imag, b_real, b_imag));
      if (out_valid && !out_stall) begin
        if (result_fifo.size() == 0) begin
          $error("result with no request pending");
          errs++;
        end else begin
          e = result_fifo.pop_front();
          if (res_real !== e.re) begin
            $error("res_real expected %0d actual %0d", e.re, res_real);
            errs++;
          end
          if (res_imag !== e.im) begin
            $error("res_imag expected %0d actual %0d", e.im, res_imag);
            errs++;
          end
          if (equal !== e.eq) begin
            $error("equal expected %0b actual %0b", e.eq, equal);
            errs++;
          end
          if (div_zero !== e.dz) begin
            $error("div_zero expected %0b actual %0b", e.dz, div_zero);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

  assign pending = result_fifo.size();
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import gia_pkg::*;

  localparam int RANDOM_REQUESTS = 530;
  localparam int QUIET_REQUESTS  = 60;   // tail of the run with no idling
  localparam int DRAIN_CYCLES    = 60;   // comfortably past the pipeline latency

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic signed [OPW-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [RES_W-1:0] res_real, res_imag;
  logic equal, div_zero;
  int fail_count, pending;
  bit quiet = 1'b0;

  always #6 clk = ~clk;

  gaussian_integer_alu_core uut (.*);

  gia_scoreboard checker_i (.*);

  // Hard stop well past the slowest legal run.
  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

  // Stall the result side in random bursts; hold it open once quiet.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        n = $urandom_range(1, 30);
        out_stall <= 1'b0;
      end else begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  // Present one request and hold it until accepted.
  task automatic send_request(logic [2:0] k, logic signed [OPW-1:0] ar,
      logic signed [OPW-1:0] ai, logic signed [OPW-1:0] br,
      logic signed [OPW-1:0] bi);
    kind     <= k;
    a_real   <= ar;
    a_imag   <= ai;
    b_real   <= br;
    b_imag   <= bi;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Idle the request side for a random burst, sometimes.
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic logic signed [OPW-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return OPW'($urandom_range(0, 6)) - 16'sd3;
      default: return OPW'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [OPW-1:0] ar, ai, br, bi;
    logic [2:0] k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: operand extremes on every kind, division by zero,
    // truncation toward zero, equal and unequal compares, unused codes.
    for (int i = 0; i < 8; i++)
      send_request(3'(i), 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_request(KIND_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(KIND_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(KIND_SUB, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_request(KIND_DIV, 16'sd5, -16'sd7, 16'sd0, 16'sd0);
    send_request(KIND_DIV, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0);
    send_request(KIND_DIV, 16'sd7, -16'sd7, 16'sd2, 16'sd0);
    send_request(KIND_DIV, -16'sd7, 16'sd7, 16'sd0, -16'sd2);
    send_request(KIND_DIV, 16'sh8000, 16'sh8000, 16'sd0, 16'sd1);
    send_request(KIND_DIV, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_request(KIND_CMP, 16'sh1234, -16'sd1, 16'sh1234, -16'sd1);
    send_request(KIND_CMP, 16'sh1234, -16'sd1, 16'sh1234, 16'sd1);
    send_request(KIND_CMP, 16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_request(KIND_CMP, 16'sd0, 16'sd0, 16'sd0, 16'sd0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS - QUIET_REQUESTS) quiet = 1'b1;
      maybe_idle();
      k  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(0, 4));
      ar = pick_operand();
      ai = pick_operand();
      br = pick_operand();
      bi = pick_operand();
      // keep compares and divide-by-zero from being vanishingly rare
      if (k == KIND_CMP && $urandom_range(0, 1)) begin
        br = ar;
        if ($urandom_range(0, 1)) bi = ai;
      end
      if (k == KIND_DIV && $urandom_range(0, 7) == 0) begin
        br = '0;
        bi = '0;
      end
      send_request(k, ar, ai, br, bi);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end
endmodule
